@@ rtl/bcc_pkg.sv @@
package bcc_pkg;

  // Field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned EVENT_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_PRESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PRESSES = 2'd3;

  // Register reset values
  localparam logic [MS_W-1:0]    DEBOUNCE_RST    = 16'd20;
  localparam logic [MS_W-1:0]    LONG_PRESS_RST  = 16'd300;
  localparam logic [MS_W-1:0]    MULTI_PRESS_RST = 16'd500;
  localparam logic [COUNT_W-1:0] MAX_PRESSES_RST = 3'd2;

  // Press count saturates here
  localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 3'd1;
  localparam logic [COUNT_W-1:0] COUNT_TWO = 3'd2;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_PRESSED  = 3'd1;
  localparam logic [EVENT_W-1:0] EV_SINGLE   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_DOUBLE   = 3'd3;
  localparam logic [EVENT_W-1:0] EV_LONG_REL = 3'd4;
  localparam logic [EVENT_W-1:0] EV_RELEASED = 3'd5;

endpackage

@@ rtl/button_click_classifier_unit.sv @@
// Debounced button click and long-press classifier.
//
// Input channel: one request per pin sample (now_ms timestamp plus the
// active-low level). Output channel: one request per sample carrying
// event_code (none, pressed, single, double, long release, release).
// Both channels use valid/stall; a request moves when valid is high and
// stall is low.
//
// A sample's event is registered and shows at out_valid in the cycle after
// it is accepted. Throughput is one sample per cycle while the receiver
// does not stall; the state update (a 32-bit subtract and compare against
// the debounce and held times) sits between the state and result registers.
// While the receiver stalls, the result register holds and in_stall rises
// only when a result is waiting and stalled, so the block still takes a
// sample in the cycle the waiting result is taken.
//
// Reset (rst, synchronous, active high) loads the default timings
// (20/300/500 ms, two presses), clears the press state and the output.
// Configuration writes on cfg_we land at once; make them only while no
// sample is in flight.
module button_click_classifier_unit
  import bcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // sample channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic                  level,
  // event channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [EVENT_W-1:0]    event_code
);

  // Configuration registers
  logic [MS_W-1:0]    debounce_ms;
  logic [MS_W-1:0]    long_press_ms;
  logic [MS_W-1:0]    multi_press_ms;
  logic [COUNT_W-1:0] max_presses;

  // Press tracking state
  logic               last_level,   last_level_next;
  logic [TIME_W-1:0]  edge_time,    edge_time_next;
  logic [TIME_W-1:0]  press_start,  press_start_next;
  logic               press_active, press_active_next;
  logic [COUNT_W-1:0] press_total,  press_total_next;
  logic               long_seen,    long_seen_next;
  logic [EVENT_W-1:0] ev_next;

  logic              in_accept;
  logic              edge_seen;
  logic              bounce;
  logic [TIME_W-1:0] gap;
  logic [TIME_W-1:0] held;
  logic              held_long;
  logic              held_multi;
  logic [COUNT_W-1:0] total_base;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms    <= DEBOUNCE_RST;
      long_press_ms  <= LONG_PRESS_RST;
      multi_press_ms <= MULTI_PRESS_RST;
      max_presses    <= MAX_PRESSES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:    debounce_ms    <= cfg_data;
        REG_LONG_PRESS:  long_press_ms  <= cfg_data;
        REG_MULTI_PRESS: multi_press_ms <= cfg_data;
        REG_MAX_PRESSES: max_presses    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Time differences wrap modulo 2^32
  assign edge_seen  = (level != last_level);
  assign gap        = now_ms - edge_time;
  assign bounce     = edge_seen && (gap < {{(TIME_W-MS_W){1'b0}}, debounce_ms});
  assign held       = now_ms - press_start;
  assign held_long  = held > {{(TIME_W-MS_W){1'b0}}, long_press_ms};
  assign held_multi = held > {{(TIME_W-MS_W){1'b0}}, multi_press_ms};
  // a fresh press sequence restarts the count from zero
  assign total_base = press_active ? press_total : '0;

  // Next state and event for one sample
  always_comb begin
    last_level_next   = last_level;
    edge_time_next    = edge_seen ? now_ms : edge_time;
    press_start_next  = press_start;
    press_active_next = press_active;
    press_total_next  = press_total;
    long_seen_next    = long_seen;
    ev_next           = EV_NONE;

    if (!bounce) begin
      last_level_next = level;
      if (!level) begin
        if (edge_seen) begin
          if (!press_active) begin
            press_start_next  = now_ms;
            press_active_next = 1'b1;
            ev_next           = EV_PRESSED;
          end
          press_total_next = (total_base < COUNT_MAX) ? total_base + COUNT_ONE
                                                      : total_base;
        end else if (press_active && !long_seen && held_long) begin
          long_seen_next = 1'b1;
        end
      end else if (press_active) begin
        if (!long_seen && (press_total >= max_presses || held_multi)) begin
          // sequence ends; other counts report nothing
          if (press_total == COUNT_ONE)      ev_next = EV_SINGLE;
          else if (press_total == COUNT_TWO) ev_next = EV_DOUBLE;
          press_active_next = 1'b0;
        end else if (long_seen) begin
          long_seen_next    = 1'b0;
          press_active_next = 1'b0;
          ev_next           = EV_LONG_REL;
        end else if (edge_seen) begin
          ev_next = EV_RELEASED;
        end
      end
    end
  end

  // State update on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= 1'b1;
      edge_time    <= '0;
      press_start  <= '0;
      press_active <= 1'b0;
      press_total  <= '0;
      long_seen    <= 1'b0;
    end else if (in_accept) begin
      last_level   <= last_level_next;
      edge_time    <= edge_time_next;
      press_start  <= press_start_next;
      press_active <= press_active_next;
      press_total  <= press_total_next;
      long_seen    <= long_seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      event_code <= ev_next;
    end
  end

endmodule

@@ rtl/bcc_checker.sv @@
module bcc_checker
  import bcc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [EVENT_W-1:0]    event_code
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_code))
    else $error("stalled result changed");

  // The input only stalls behind a waiting, stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // Every accepted sample yields a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted sample produced no result");

  // A taken result with no new sample leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
    else $error("result repeated");

  // Only defined event codes appear
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_code <= EV_RELEASED)
    else $error("undefined event code");

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (.*);

@@ tb/button_click_classifier_unit_test.sv @@
module button_click_classifier_unit_test
  import bcc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the classifier state and the events still owed by the block
  class click_scoreboard;
    logic [MS_W-1:0]     debounce_ms;
    logic [MS_W-1:0]     long_press_ms;
    logic [MS_W-1:0]     multi_press_ms;
    logic [COUNT_W-1:0]  max_presses;
    logic                last_level;
    logic [TIME_W-1:0]   edge_time;
    logic [TIME_W-1:0]   press_start;
    logic                press_active;
    logic [COUNT_W-1:0]  press_total;
    logic                long_seen;
    logic [EVENT_W-1:0]  owed_events[$];
    int unsigned         errors;

    function new();
      debounce_ms    = DEBOUNCE_RST;
      long_press_ms  = LONG_PRESS_RST;
      multi_press_ms = MULTI_PRESS_RST;
      max_presses    = MAX_PRESSES_RST;
      last_level     = 1'b1;
      edge_time      = '0;
      press_start    = '0;
      press_active   = 1'b0;
      press_total    = '0;
      long_seen      = 1'b0;
      errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEBOUNCE:    debounce_ms    = data;
        REG_LONG_PRESS:  long_press_ms  = data;
        REG_MULTI_PRESS: multi_press_ms = data;
        default:         max_presses    = data[COUNT_W-1:0];
      endcase
    endfunction

    function int unsigned pending();
      return owed_events.size();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Classify one accepted pin sample and queue the event it owes
    task note_sample(logic [TIME_W-1:0] now, logic lvl);
      logic [EVENT_W-1:0] ev;
      logic [TIME_W-1:0]  gap;
      logic               edge_seen;
      ev = EV_NONE;
      edge_seen = (lvl != last_level);
      if (edge_seen) begin
        gap = now - edge_time;
        edge_time = now;
        // bounce: level change too soon, level stays as it was
        if (gap < {16'd0, debounce_ms}) begin
          owed_events.push_back(EV_NONE);
          return;
        end
      end
      if (lvl == 1'b0) begin
        if (edge_seen) begin
          if (!press_active) begin
            press_start  = now;
            press_active = 1'b1;
            press_total  = '0;
            ev = EV_PRESSED;
          end
          if (press_total < COUNT_MAX) press_total++;
        end else if (press_active && !long_seen &&
                     (now - press_start) > {16'd0, long_press_ms}) begin
          long_seen = 1'b1;
        end
      end else if (press_active) begin
        if (!long_seen && (press_total >= max_presses ||
                           (now - press_start) > {16'd0, multi_press_ms})) begin
          // sequence ends; counts other than one or two report nothing
          if (press_total == COUNT_ONE) ev = EV_SINGLE;
          else if (press_total == COUNT_TWO) ev = EV_DOUBLE;
          press_active = 1'b0;
        end else if (long_seen) begin
          long_seen    = 1'b0;
          press_active = 1'b0;
          ev = EV_LONG_REL;
        end else if (edge_seen) begin
          ev = EV_RELEASED;
        end
      end
      last_level = lvl;
      owed_events.push_back(ev);
    endtask

    task check_event(logic [EVENT_W-1:0] got);
      logic [EVENT_W-1:0] want;
      if (owed_events.size() == 0) begin
        report($sformatf("event %0d with no sample outstanding", got));
        return;
      end
      want = owed_events.pop_front();
      if (got !== want)
        report($sformatf("event_code %0d, predicted %0d", got, want));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [TIME_W-1:0]     now_ms;
  logic                  level;
  logic                  out_valid;
  logic                  out_stall;
  logic [EVENT_W-1:0]    event_code;

  click_scoreboard sb = new();
  bit              idle_off;

  // Timing settings per random phase: debounce, long press, window, press count
  int unsigned deb_set[9]   = '{5, 0, 10, 3, 0, 8, 65535, 2, 1};
  int unsigned long_set[9]  = '{40, 30, 0, 50, 20, 60, 65535, 25, 30};
  int unsigned multi_set[9] = '{80, 60, 0, 200, 100, 150, 65535, 90, 45};
  int unsigned max_set[9]   = '{2, 3, 1, 4, 0, 7, 5, 6, 1};

  button_click_classifier_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .now_ms     (now_ms),
    .level      (level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_code (event_code)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Accepted requests on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_sample(now_ms, level);
      if (out_valid && !out_stall) sb.check_event(event_code);
    end
  end

  // Event receiver: random stall ahead of each request
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = idle_off ? 0 : $urandom_range(0, 4);
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Send one sample request; returns at the edge that takes it
  task automatic send_sample(logic [TIME_W-1:0] t, logic lvl);
    int unsigned gap;
    gap = idle_off ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    now_ms   <= t;
    level    <= lvl;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off until every owed event has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // Random samples with time steps aimed around the current thresholds
  task automatic run_phase(int unsigned count);
    logic [TIME_W-1:0] t;
    logic              lvl;
    int unsigned       span;
    int unsigned       mark;
    int unsigned       roll;
    t = $urandom;
    lvl = sb.last_level;
    span = 32'(sb.debounce_ms);
    if (sb.long_press_ms > span) span = 32'(sb.long_press_ms);
    if (sb.multi_press_ms > span) span = 32'(sb.multi_press_ms);
    span = span + 1;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        t += $urandom_range(0, sb.debounce_ms);
      end else if (roll < 75) begin
        t += $urandom_range(0, span * 2);
      end else if (roll < 95) begin
        case ($urandom_range(0, 2))
          0:       mark = 32'(sb.debounce_ms);
          1:       mark = 32'(sb.long_press_ms);
          default: mark = 32'(sb.multi_press_ms);
        endcase
        t += mark + $urandom_range(0, 4) - 2;
      end else begin
        t = $urandom;
      end
      if ($urandom_range(0, 99) < 60) lvl = ~lvl;
      send_sample(t, lvl);
    end
    drain_results();
  endtask

  initial begin
    #2_000_000;
    $display("button_click_classifier_unit_test failed");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    now_ms    = '0;
    level     = 1'b1;
    idle_off  = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed samples at the reset timings (20 / 300 / 500 ms, two presses)
    send_sample(32'd5, 1'b1);             // steady release, nothing
    send_sample(32'd20, 1'b0);            // press exactly at debounce spacing
    send_sample(32'd39, 1'b1);            // bounce, rejected
    send_sample(32'd120, 1'b1);           // real release inside window
    send_sample(32'd170, 1'b0);           // second press
    send_sample(32'd220, 1'b1);           // double click
    send_sample(32'd1000, 1'b0);
    send_sample(32'd1300, 1'b0);          // held exactly the long time
    send_sample(32'd1301, 1'b0);          // now long
    send_sample(32'd1400, 1'b1);          // long press release
    send_sample(32'd2000, 1'b0);
    send_sample(32'd2100, 1'b1);
    send_sample(32'd2500, 1'b1);          // window edge, still open
    send_sample(32'd2501, 1'b1);          // single click
    send_sample(32'hFFFF_FFF0, 1'b0);     // press just before wrap
    send_sample(32'h0000_0010, 1'b1);     // release after wrap
    send_sample(32'h0000_0400, 1'b1);     // single click across wrap
    drain_results();

    // Random phases, each under its own timing set
    for (int p = 0; p < 9; p++) begin
      idle_off = (p == 2 || p == 6);
      write_reg(REG_DEBOUNCE, deb_set[p][CFG_DATA_W-1:0]);
      write_reg(REG_LONG_PRESS, long_set[p][CFG_DATA_W-1:0]);
      write_reg(REG_MULTI_PRESS, multi_set[p][CFG_DATA_W-1:0]);
      // upper data bits are random, only the low count bits land
      write_reg(REG_MAX_PRESSES,
                {13'($urandom_range(0, 8191)), max_set[p][COUNT_W-1:0]});
      run_phase(56);
    end

    idle_off = 1'b0;
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d events never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("button_click_classifier_unit_test passed");
    end else begin
      $display("button_click_classifier_unit_test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bcc_pkg.sv
rtl/button_click_classifier_unit.sv
rtl/bcc_checker.sv
tb/button_click_classifier_unit_test.sv
